[rtl/pttt_pkg.sv]
// ----------------------------------------------------------------------------
// pttt_pkg
// Shared types and constants of the periodic task timer table.
// ----------------------------------------------------------------------------
package pttt_pkg;

   localparam int ENTRIES   = 16;
   localparam int ID_BITS   = 16;
   localparam int TIME_BITS = 16;
   localparam int IDX_BITS  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_BITS  = $clog2(ENTRIES + 1);

   localparam logic [2:0] OP_SET      = 3'd0;
   localparam logic [2:0] OP_CLEAR    = 3'd1;
   localparam logic [2:0] OP_TICK     = 3'd2;
   localparam logic [2:0] OP_DISPATCH = 3'd3;
   localparam logic [2:0] OP_COMPLETE = 3'd4;
   localparam logic [2:0] OP_DEAD     = 3'd5;

   localparam logic [2:0] STAT_WAIT    = 3'd0;
   localparam logic [2:0] STAT_READY   = 3'd1;
   localparam logic [2:0] STAT_RUNNING = 3'd2;
   localparam logic [2:0] STAT_DONE    = 3'd3;
   localparam logic [2:0] STAT_DEAD    = 3'd4;

   localparam logic [1:0] SC_FULL      = 2'd0;
   localparam logic [1:0] SC_REWRITTEN = 2'd1;
   localparam logic [1:0] SC_ADDED     = 2'd2;
   localparam logic [1:0] SC_REFUSED   = 2'd3;

   typedef struct packed {
      logic [2:0]  req_type;
      logic [15:0] task_id;
      logic [15:0] start_delay;
      logic [15:0] run_period;
   } req_item_type;

   typedef struct packed {
      logic [1:0]  set_code;
      logic        found;
      logic [15:0] run_task;
      logic        run_once_removed;
      logic [4:0]  task_count;
   } rsp_item_type;

   typedef struct packed {
      logic [ID_BITS-1:0]   task_id;
      logic [TIME_BITS-1:0] delay;
      logic [TIME_BITS-1:0] period;
      logic [2:0]           status;
   } entry_type;

   typedef struct packed {
      logic [2:0]           op;
      logic [ID_BITS-1:0]   id;
      logic [TIME_BITS-1:0] dly;
      logic [TIME_BITS-1:0] per;
      logic                 live;
      logic                 at_append;
      logic                 hit;
   } head_ctl_type;

   typedef struct packed {
      logic       first;
      logic [1:0] code;
      logic       append;
      logic       remove;
   } head_evt_type;

endpackage

[rtl/pttt_cell.sv]
// ----------------------------------------------------------------------------
// pttt_cell
// One slot of the rotating entry ring; takes its neighbor's entry on shift.
// ----------------------------------------------------------------------------
module pttt_cell (
   input  logic               clock,
   input  logic               shift,
   input  pttt_pkg::entry_type entry_in,
   output pttt_pkg::entry_type entry_out
);
   import pttt_pkg::*;

   entry_type entry_ff;
   entry_type entry_in_d;

   always_comb begin
      entry_in_d = shift ? entry_in : entry_ff;
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in_d;
   end

   assign entry_out = entry_ff;

endmodule

[rtl/pttt_head.sv]
// ----------------------------------------------------------------------------
// pttt_head
// Applies the current request to the one entry passing the head of the ring.
// ----------------------------------------------------------------------------
module pttt_head (
   input  pttt_pkg::head_ctl_type ctl,
   input  pttt_pkg::entry_type    entry_in,
   output pttt_pkg::entry_type    entry_out,
   output pttt_pkg::head_evt_type evt
);
   import pttt_pkg::*;

   logic is_match;

   always_comb begin
      entry_out = entry_in;
      evt       = '0;
      is_match  = ctl.live && !ctl.hit && (entry_in.task_id == ctl.id);
      case (ctl.op)
         OP_SET: begin
            if (is_match) begin
               evt.first = 1'b1;
               if (entry_in.status == STAT_DEAD) begin
                  evt.code = SC_REFUSED;
               end else begin
                  entry_out.delay  = ctl.dly;
                  entry_out.period = ctl.per;
                  entry_out.status = STAT_WAIT;
                  evt.code         = SC_REWRITTEN;
               end
            end else if (ctl.at_append && !ctl.hit) begin
               entry_out.task_id = ctl.id;
               entry_out.delay   = ctl.dly;
               entry_out.period  = ctl.per;
               entry_out.status  = STAT_WAIT;
               evt.first         = 1'b1;
               evt.append        = 1'b1;
               evt.code          = SC_ADDED;
            end
         end
         OP_CLEAR: begin
            if (is_match) begin
               evt.first  = 1'b1;
               evt.remove = 1'b1;
            end
         end
         OP_TICK: begin
            if (ctl.live && (entry_in.status == STAT_WAIT || entry_in.status == STAT_DONE))
            begin
               if (entry_in.delay != '0) begin
                  entry_out.delay = entry_in.delay - TIME_BITS'(1);
               end else begin
                  entry_out.status = STAT_READY;
               end
            end
         end
         OP_DISPATCH: begin
            if (ctl.live && !ctl.hit && entry_in.status == STAT_READY) begin
               evt.first = 1'b1;
               if (entry_in.period == '0) begin
                  evt.remove = 1'b1;
               end else begin
                  entry_out.delay  = entry_in.period;
                  entry_out.status = STAT_RUNNING;
               end
            end
         end
         OP_COMPLETE: begin
            if (is_match) begin
               evt.first = 1'b1;
               if (entry_in.status == STAT_RUNNING) begin
                  entry_out.status = STAT_DONE;
               end
            end
         end
         OP_DEAD: begin
            if (is_match) begin
               evt.first        = 1'b1;
               entry_out.status = STAT_DEAD;
            end
         end
         default: begin
            entry_out = entry_in;
         end
      endcase
   end

endmodule

[rtl/periodic_task_timer_table.sv]
// ----------------------------------------------------------------------------
// periodic_task_timer_table
// Task timer table held in a ring of cells that rotates one or two laps per request.
// ----------------------------------------------------------------------------
// A request turns the ring one full lap, and a clear or a dispatch that removes
// an entry turns it a second lap to move the last entry into the hole. A new
// request is taken only once the result of the last one has been registered,
// so a stalled result also holds off the next request.
// Reset clears the entry count and the control; entry contents are not cleared.
module periodic_task_timer_table (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  pttt_pkg::req_item_type req_item,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output pttt_pkg::rsp_item_type rsp_item
);
   import pttt_pkg::*;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_PASS1 = 2'd1;
   localparam logic [1:0] S_PASS2 = 2'd2;
   localparam logic [1:0] S_DONE  = 2'd3;

   logic [1:0]          state_ff, state_in;
   logic [IDX_BITS-1:0] k_ff, k_in;
   logic [CNT_BITS-1:0] used_ff, used_in;
   logic [IDX_BITS-1:0] idx_ff, idx_in;
   logic                hit_ff, hit_in;
   logic                remove_ff, remove_in;
   logic [1:0]          code_ff, code_in;
   logic [ID_BITS-1:0]  run_ff, run_in;
   entry_type           hold_ff, hold_in;
   req_item_type        req_ff, req_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_item_type        rsp_item_ff, rsp_item_in;

   entry_type    cell_q [ENTRIES];
   entry_type    ring_in;
   entry_type    head_out;
   head_ctl_type ctl;
   head_evt_type evt;
   logic         shift;
   logic         lap_end;
   logic         at_last;

   assign shift   = (state_ff == S_PASS1) || (state_ff == S_PASS2);
   assign lap_end = (k_ff == IDX_BITS'(ENTRIES - 1));
   assign at_last = ctl.live && ((CNT_BITS'(k_ff) + CNT_BITS'(1)) == used_ff);

   always_comb begin
      ctl.op        = req_ff.req_type;
      ctl.id        = ID_BITS'(req_ff.task_id);
      ctl.dly       = TIME_BITS'(req_ff.start_delay);
      ctl.per       = TIME_BITS'(req_ff.run_period);
      ctl.live      = CNT_BITS'(k_ff) < used_ff;
      ctl.at_append = CNT_BITS'(k_ff) == used_ff;
      ctl.hit       = hit_ff;
   end

   pttt_head u_head (
      .ctl       (ctl),
      .entry_in  (cell_q[0]),
      .entry_out (head_out),
      .evt       (evt)
   );

   always_comb begin
      if (state_ff == S_PASS2) begin
         ring_in = (k_ff == idx_ff) ? hold_ff : cell_q[0];
      end else begin
         ring_in = head_out;
      end
   end

   for (genvar j = 0; j < ENTRIES; j++) begin : g_cell
      entry_type nb;
      if (j == ENTRIES - 1) begin : g_tail
         assign nb = ring_in;
      end else begin : g_mid
         assign nb = cell_q[j + 1];
      end
      pttt_cell u_cell (
         .clock     (clock),
         .shift     (shift),
         .entry_in  (nb),
         .entry_out (cell_q[j])
      );
   end

   always_comb begin
      state_in     = state_ff;
      k_in         = k_ff;
      used_in      = used_ff;
      idx_in       = idx_ff;
      hit_in       = hit_ff;
      remove_in    = remove_ff;
      code_in      = code_ff;
      run_in       = run_ff;
      hold_in      = hold_ff;
      req_in       = req_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_item_in  = rsp_item_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in    = req_item;
               k_in      = '0;
               hit_in    = 1'b0;
               remove_in = 1'b0;
               code_in   = SC_FULL;
               run_in    = '0;
               state_in  = S_PASS1;
            end
         end
         S_PASS1: begin
            if (evt.first) begin
               hit_in  = 1'b1;
               idx_in  = k_ff;
               code_in = evt.code;
               if (req_ff.req_type == OP_DISPATCH) begin
                  run_in = cell_q[0].task_id;
               end
            end
            if (evt.remove) begin
               remove_in = 1'b1;
            end
            if (at_last) begin
               hold_in = cell_q[0];
            end
            if (evt.append) begin
               used_in = used_ff + CNT_BITS'(1);
            end
            if (lap_end) begin
               k_in     = '0;
               state_in = (remove_ff || evt.remove) ? S_PASS2 : S_DONE;
            end else begin
               k_in = k_ff + IDX_BITS'(1);
            end
         end
         S_PASS2: begin
            if (lap_end) begin
               k_in     = '0;
               used_in  = used_ff - CNT_BITS'(1);
               state_in = S_DONE;
            end else begin
               k_in = k_ff + IDX_BITS'(1);
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in                 = 1'b1;
               rsp_item_in.set_code         = (req_ff.req_type == OP_SET) ? code_ff : SC_FULL;
               rsp_item_in.found            = hit_ff && (req_ff.req_type != OP_SET);
               rsp_item_in.run_task         = 16'(run_ff);
               rsp_item_in.run_once_removed = remove_ff && (req_ff.req_type == OP_DISPATCH);
               rsp_item_in.task_count       = 5'(used_ff);
               state_in                     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         k_ff         <= '0;
         used_ff      <= '0;
         hit_ff       <= 1'b0;
         remove_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         k_ff         <= k_in;
         used_ff      <= used_in;
         hit_ff       <= hit_in;
         remove_ff    <= remove_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      code_ff     <= code_in;
      run_ff      <= run_in;
      hold_ff     <= hold_in;
      req_ff      <= req_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

[rtl/pttt_checker.sv]
// ----------------------------------------------------------------------------
// pttt_checker
// Port-level checks of the periodic task timer table.
// ----------------------------------------------------------------------------
module pttt_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input pttt_pkg::rsp_item_type rsp_item
);
   import pttt_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))
      else $error("Stalled result item changed or was dropped.");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_item.task_count <= 5'(ENTRIES)))
      else $error("Task count exceeds the table size.");

   a_set_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_item.set_code != SC_FULL) |->
         !rsp_item.found && (rsp_item.run_task == '0) && !rsp_item.run_once_removed)
      else $error("Set result carries fields of another request.");

   a_removed_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.run_once_removed |-> rsp_item.found)
      else $error("Removal reported without a dispatched entry.");

   a_no_quick_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("Input taken again right after an accepted item.");

endmodule

bind periodic_task_timer_table pttt_checker u_pttt_checker (.*);

[bench/tb_periodic_task_timer_table.sv]
// ----------------------------------------------------------------------------
// tb_periodic_task_timer_table
// Self-checking bench for the task timer table. A shadow copy of the table
// predicts the response to every accepted request, and each response is
// compared field by field in order. Directed requests cover the corner cases,
// then random bursts from a small id pool keep the table busy and often full,
// while the response side stalls on its own pattern and once holds off long.
// ----------------------------------------------------------------------------
module tb_periodic_task_timer_table;
   timeunit 1ns;
   timeprecision 1ps;

   import pttt_pkg::*;

   localparam logic [2:0] OP_SPARE_LO = 3'd6;
   localparam logic [2:0] OP_SPARE_HI = 3'd7;
   localparam int RANDOM_ITEMS = 2000;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int HOLD_CYCLES  = 600;

   class task_table_shadow;
      logic [ID_BITS-1:0]   ent_id     [ENTRIES];
      logic [TIME_BITS-1:0] ent_delay  [ENTRIES];
      logic [TIME_BITS-1:0] ent_period [ENTRIES];
      logic [2:0]           ent_status [ENTRIES];
      int                   used;
      int                   checked;
      int                   errors;
      rsp_item_type         awaited_responses [$];

      function new();
         used    = 0;
         checked = 0;
         errors  = 0;
      endfunction

      function int find_id(logic [ID_BITS-1:0] id);
         for (int i = 0; i < used; i++) begin
            if (ent_id[i] == id) return i;
         end
         return -1;
      endfunction

      function void drop_entry(int idx);
         int last;
         last = used - 1;
         ent_id[idx]     = ent_id[last];
         ent_delay[idx]  = ent_delay[last];
         ent_period[idx] = ent_period[last];
         ent_status[idx] = ent_status[last];
         used = last;
      endfunction

      function rsp_item_type apply_request(req_item_type rq);
         rsp_item_type r;
         int           hit;
         r   = '0;
         hit = find_id(rq.task_id);
         case (rq.req_type)
            OP_SET: begin
               if (hit >= 0) begin
                  if (ent_status[hit] == STAT_DEAD) begin
                     r.set_code = SC_REFUSED;
                  end else begin
                     ent_delay[hit]  = rq.start_delay;
                     ent_period[hit] = rq.run_period;
                     ent_status[hit] = STAT_WAIT;
                     r.set_code      = SC_REWRITTEN;
                  end
               end else if (used < ENTRIES) begin
                  ent_id[used]     = rq.task_id;
                  ent_delay[used]  = rq.start_delay;
                  ent_period[used] = rq.run_period;
                  ent_status[used] = STAT_WAIT;
                  used++;
                  r.set_code = SC_ADDED;
               end else begin
                  r.set_code = SC_FULL;
               end
            end
            OP_CLEAR: begin
               if (hit >= 0) begin
                  drop_entry(hit);
                  r.found = 1'b1;
               end
            end
            OP_TICK: begin
               for (int i = 0; i < used; i++) begin
                  if (ent_status[i] == STAT_WAIT || ent_status[i] == STAT_DONE) begin
                     if (ent_delay[i] != '0) ent_delay[i] = ent_delay[i] - 1'b1;
                     else ent_status[i] = STAT_READY;
                  end
               end
            end
            OP_DISPATCH: begin
               for (int i = 0; i < used; i++) begin
                  if (ent_status[i] == STAT_READY) begin
                     r.found    = 1'b1;
                     r.run_task = ent_id[i];
                     if (ent_period[i] == '0) begin
                        drop_entry(i);
                        r.run_once_removed = 1'b1;
                     end else begin
                        ent_delay[i]  = ent_period[i];
                        ent_status[i] = STAT_RUNNING;
                     end
                     break;
                  end
               end
            end
            OP_COMPLETE: begin
               if (hit >= 0) begin
                  r.found = 1'b1;
                  if (ent_status[hit] == STAT_RUNNING) ent_status[hit] = STAT_DONE;
               end
            end
            OP_DEAD: begin
               if (hit >= 0) begin
                  r.found         = 1'b1;
                  ent_status[hit] = STAT_DEAD;
               end
            end
            default: ;
         endcase
         r.task_count = used[4:0];
         return r;
      endfunction

      function void note_request(req_item_type rq);
         awaited_responses.push_back(apply_request(rq));
      endfunction

      function void compare_field(string name, logic [15:0] want, logic [15:0] got);
         if (got !== want) begin
            $error("%s expected %0h actual %0h", name, want, got);
            errors++;
         end
      endfunction

      function void check_response(rsp_item_type got);
         rsp_item_type want;
         checked++;
         if (awaited_responses.size() == 0) begin
            $error("response %0h arrived with no request outstanding", got);
            errors++;
            return;
         end
         want = awaited_responses.pop_front();
         compare_field("set_code", 16'(want.set_code), 16'(got.set_code));
         compare_field("found", 16'(want.found), 16'(got.found));
         compare_field("run_task", want.run_task, got.run_task);
         compare_field("run_once_removed", 16'(want.run_once_removed),
                       16'(got.run_once_removed));
         compare_field("task_count", 16'(want.task_count), 16'(got.task_count));
      endfunction

      function int pending();
         return awaited_responses.size();
      endfunction
   endclass

   logic         clock = 1'b0;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   req_item_type req_item;
   logic         rsp_valid;
   logic         rsp_stall;
   rsp_item_type rsp_item;

   task_table_shadow tracker = new();
   int               cycle_count = 0;
   int               burst_left = 0;

   periodic_task_timer_table uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("periodic_task_timer_table verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) tracker.check_response(rsp_item);
   end

   // The response side changes its stall habit every so often and, once enough
   // items have come back, holds off long enough for the input to back up.
   initial begin : receiver
      int mode;
      int left;
      bit held;
      mode = 0;
      left = 0;
      held = 1'b0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (!held && tracker.checked >= 200) begin
            held = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else begin
            if (left == 0) begin
               mode = $urandom_range(0, 3);
               left = $urandom_range(20, 200);
            end
            left--;
            case (mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 3) == 0);
               2: rsp_stall <= ($urandom_range(0, 3) != 0);
               default: rsp_stall <= left[0];
            endcase
         end
      end
   end

   function automatic req_item_type make_request(logic [2:0] op, logic [15:0] id,
                                                 logic [15:0] dly, logic [15:0] per);
      req_item_type rq;
      rq.req_type    = op;
      rq.task_id     = id;
      rq.start_delay = dly;
      rq.run_period  = per;
      return rq;
   endfunction

   // Most ids come from a small pool so requests hit existing tasks and the
   // table fills up; the rest are full-width values.
   function automatic req_item_type random_request();
      int          pick;
      logic [2:0]  op;
      logic [15:0] id;
      logic [15:0] dly;
      logic [15:0] per;
      pick = $urandom_range(0, 99);
      if (pick < 33) op = OP_SET;
      else if (pick < 55) op = OP_TICK;
      else if (pick < 73) op = OP_DISPATCH;
      else if (pick < 81) op = OP_CLEAR;
      else if (pick < 90) op = OP_COMPLETE;
      else if (pick < 95) op = OP_DEAD;
      else if (pick < 97) op = OP_SPARE_LO;
      else op = OP_SPARE_HI;
      id = ($urandom_range(0, 99) < 85) ? 16'($urandom_range(0, 19)) : 16'($urandom);
      dly = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
      pick = $urandom_range(0, 9);
      if (pick < 2) per = '0;
      else if (pick < 9) per = 16'($urandom_range(1, 4));
      else per = 16'($urandom);
      return make_request(op, id, dly, per);
   endfunction

   task automatic offer(input req_item_type rq);
      req_item  <= rq;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      tracker.note_request(rq);
      @(negedge clock);
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         int gap;
         gap = $urandom_range(0, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 30);
      end
   endtask

   initial begin : sender
      req_item_type directed [$];
      reset     = 1'b1;
      req_valid = 1'b0;
      req_item  = '0;
      directed = '{
         make_request(OP_SET, 16'h0000, 16'h0000, 16'h0000),
         make_request(OP_SET, 16'hFFFF, 16'hFFFF, 16'hFFFF),
         make_request(OP_SET, 16'h0001, 16'h0001, 16'h0002),
         make_request(OP_DISPATCH, 16'h0000, 16'h0000, 16'h0000),
         make_request(OP_TICK, 16'h0000, 16'h0000, 16'h0000),
         make_request(OP_TICK, 16'h0000, 16'h0000, 16'h0000),
         make_request(OP_DISPATCH, 16'h0000, 16'h0000, 16'h0000),
         make_request(OP_DISPATCH, 16'h0000, 16'h0000, 16'h0000),
         make_request(OP_COMPLETE, 16'h0001, 16'h0000, 16'h0000),
         make_request(OP_COMPLETE, 16'h0001, 16'h0000, 16'h0000),
         make_request(OP_COMPLETE, 16'h1234, 16'h0000, 16'h0000),
         make_request(OP_SET, 16'h0001, 16'h0005, 16'h0005),
         make_request(OP_DEAD, 16'hFFFF, 16'h0000, 16'h0000),
         make_request(OP_DEAD, 16'hFFFF, 16'h0000, 16'h0000),
         make_request(OP_SET, 16'hFFFF, 16'h0000, 16'h0003),
         make_request(OP_TICK, 16'h0000, 16'h0000, 16'h0000),
         make_request(OP_DISPATCH, 16'h0000, 16'h0000, 16'h0000),
         make_request(OP_CLEAR, 16'hFFFF, 16'h0000, 16'h0000),
         make_request(OP_CLEAR, 16'hFFFF, 16'h0000, 16'h0000),
         make_request(OP_DEAD, 16'h4321, 16'h0000, 16'h0000),
         make_request(OP_SPARE_LO, 16'h5A5A, 16'hA5A5, 16'h0F0F),
         make_request(OP_SPARE_HI, 16'hFFFF, 16'hFFFF, 16'hFFFF),
         make_request(OP_CLEAR, 16'h0001, 16'h0000, 16'h0000)
      };
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      burst_left = $urandom_range(1, 30);
      foreach (directed[i]) offer(directed[i]);
      repeat (RANDOM_ITEMS) offer(random_request());
      req_valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (2 * ENTRIES + 4) @(posedge clock);
      if (tracker.errors == 0) begin
         $display("periodic_task_timer_table verification clean");
      end else begin
         $display("periodic_task_timer_table verification failed");
      end
      $finish;
   end

endmodule
